// ----- design/ptb_pkg.sv -----
// shared types and constants for the periodic timer slot bank
package ptb_pkg;

    localparam int NUM_SLOTS_DEF = 3;
    localparam int MAX_SLOTS     = 16;

    localparam int OP_W    = 2;
    localparam int PERIOD_W = 32;
    localparam int ID_W    = 8;
    localparam int PARAM_W = 32;
    localparam int SLOT_W  = 5;
    localparam int MASK_W  = MAX_SLOTS;

    localparam logic [SLOT_W-1:0] NO_SLOT = '1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_REGISTER   = 2'd1,
        OP_REMOVE     = 2'd2,
        OP_REMOVE_ALL = 2'd3
    } op_t;

endpackage

// ----- design/ptb_if.sv -----
// command and response channel interfaces of the timer bank
interface ptb_cmd_if;
    import ptb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [PERIOD_W-1:0]       period;
    logic signed [ID_W-1:0]    remove_id;
    logic [PARAM_W-1:0]        tick_param;

    modport source (output valid, output operation, output period, output remove_id,
                    output tick_param, input ready);
    modport sink   (input valid, input operation, input period, input remove_id,
                    input tick_param, output ready);
endinterface

interface ptb_rsp_if;
    import ptb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SLOT_W-1:0]  assigned_slot;
    logic [MASK_W-1:0]         fired_mask;
    logic [PARAM_W-1:0]        param_echo;

    modport source (output valid, output assigned_slot, output fired_mask,
                    output param_echo, input ready);
    modport sink   (input valid, input assigned_slot, input fired_mask,
                    input param_echo, output ready);
endinterface

// ----- design/periodic_timer_bank_with_slots.sv -----
// top level of the periodic timer slot bank
//
// cmd carries one operation per beat: tick, register slot, remove by id or
// remove all. rsp returns exactly one beat per command beat, in order.
// every slot has its own counter, period and flags; a tick updates all active
// slots at once, and register and remove pick their slot through a
// priority encoder over the slot flags and the id matches.
// latency: the response beat is valid in the cycle after the command beat
// is taken. throughput: one command per cycle while rsp is not stalled, set by the
// single output register that holds each response.
// while rsp is stalled, cmd.ready drops until the held response is taken;
// a command is taken in the same cycle that the held response leaves.
// reset clears every slot (inactive, unnamed, count and period zero) and
// empties the output register.
module periodic_timer_bank_with_slots #(
    parameter int NUM_SLOTS = ptb_pkg::NUM_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ptb_cmd_if.sink    cmd,
    ptb_rsp_if.source  rsp
);
    import ptb_pkg::*;

    logic                 slot_active_reg [NUM_SLOTS];
    logic                 slot_named_reg  [NUM_SLOTS];
    logic [PERIOD_W-1:0]  slot_count_reg  [NUM_SLOTS];
    logic [PERIOD_W-1:0]  slot_period_reg [NUM_SLOTS];
    logic                 slot_active_next [NUM_SLOTS];
    logic                 slot_named_next  [NUM_SLOTS];
    logic [PERIOD_W-1:0]  slot_count_next  [NUM_SLOTS];
    logic [PERIOD_W-1:0]  slot_period_next [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] id_match;

    logic                 rsp_valid_reg;
    logic [SLOT_W-1:0]    assigned_reg;
    logic [SLOT_W-1:0]    assigned_next;
    logic [MASK_W-1:0]    mask_reg;
    logic [MASK_W-1:0]    mask_next;
    logic [PARAM_W-1:0]   echo_reg;
    logic [PARAM_W-1:0]   echo_next;

    logic                 accept;
    op_t                  op;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign op        = op_t'(cmd.operation);

    // slot id is its index once named, zero before
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_named_reg[i])
                id_match[i] = (cmd.remove_id == ID_W'(i));
            else
                id_match[i] = (cmd.remove_id == '0);
        end
    end

    always_comb
    begin
        logic found;
        found         = 1'b0;
        assigned_next = NO_SLOT;
        mask_next     = '0;
        echo_next     = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_active_next[i] = slot_active_reg[i];
            slot_named_next[i]  = slot_named_reg[i];
            slot_count_next[i]  = slot_count_reg[i];
            slot_period_next[i] = slot_period_reg[i];
        end
        unique case (op)
            OP_TICK:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_active_reg[i])
                    begin
                        if ((slot_count_reg[i] + 32'd1) >= slot_period_reg[i])
                        begin
                            slot_count_next[i] = '0;
                            mask_next[i]       = 1'b1;
                        end
                        else
                        begin
                            slot_count_next[i] = slot_count_reg[i] + 32'd1;
                        end
                    end
                end
                echo_next = cmd.tick_param;
            end
            OP_REGISTER:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && !slot_active_reg[i])
                    begin
                        found               = 1'b1;
                        slot_count_next[i]  = '0;
                        slot_period_next[i] = cmd.period;
                        slot_named_next[i]  = 1'b1;
                        slot_active_next[i] = 1'b1;
                        assigned_next       = SLOT_W'(i);
                    end
                end
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && id_match[i])
                    begin
                        found               = 1'b1;
                        slot_active_next[i] = 1'b0;
                    end
                end
            end
            OP_REMOVE_ALL:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    slot_active_next[i] = 1'b0;
                    slot_named_next[i]  = 1'b1;
                    slot_count_next[i]  = '0;
                    slot_period_next[i] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_active_reg[i] <= 1'b0;
                slot_named_reg[i]  <= 1'b0;
                slot_count_reg[i]  <= '0;
                slot_period_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_active_reg[i] <= slot_active_next[i];
                slot_named_reg[i]  <= slot_named_next[i];
                slot_count_reg[i]  <= slot_count_next[i];
                slot_period_reg[i] <= slot_period_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            assigned_reg <= assigned_next;
            mask_reg     <= mask_next;
            echo_reg     <= echo_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.assigned_slot = assigned_reg;
    assign rsp.fired_mask    = mask_reg;
    assign rsp.param_echo    = echo_reg;

endmodule

// ----- design/ptb_checker.sv -----
// port-level checks for the timer bank, bound to the top level
module ptb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [ptb_pkg::SLOT_W-1:0]   rsp_assigned_slot,
    input logic [ptb_pkg::MASK_W-1:0]   rsp_fired_mask,
    input logic [ptb_pkg::PARAM_W-1:0]  rsp_param_echo
);
    import ptb_pkg::*;

    // every command beat yields a response in the next cycle
    a_cmd_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid)
    else $error("no response after command beat");

    // command side only stalls behind a stalled response
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> rsp_valid && !rsp_ready)
    else $error("command stalled without a stalled response");

    // a granted slot comes only from register, which fires nothing
    a_slot_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_assigned_slot != NO_SLOT) |->
            (rsp_fired_mask == '0) && (rsp_param_echo == '0))
    else $error("register response carries tick data");

    // a held response keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_assigned_slot)
            && $stable(rsp_fired_mask) && $stable(rsp_param_echo))
    else $error("stalled response changed");

endmodule

bind periodic_timer_bank_with_slots ptb_checker u_ptb_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_assigned_slot (rsp.assigned_slot),
    .rsp_fired_mask    (rsp.fired_mask),
    .rsp_param_echo    (rsp.param_echo)
);

// ----- tb/periodic_timer_bank_with_slots_tb.sv -----
// self-checking testbench for the periodic timer slot bank
module periodic_timer_bank_with_slots_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    localparam int  SLOTS       = NUM_SLOTS_DEF;
    localparam int  RAND_ITEMS  = 1425;
    localparam int  QUIET_TAIL  = 150;
    localparam int  CYCLE_LIMIT = 250000;
    localparam int  DRAIN_LIMIT = 2000;
    localparam int  PRINT_CAP   = 50;
    localparam real HALF_PERIOD = 6.0;

    typedef struct {
        op_t                  op;
        logic [PERIOD_W-1:0]  period;
        logic signed [ID_W-1:0] id;
        logic [PARAM_W-1:0]   param;
    } timer_cmd_t;

    typedef struct {
        logic [SLOT_W-1:0]   slot;
        logic [MASK_W-1:0]   mask;
        logic [PARAM_W-1:0]  echo;
    } timer_rsp_t;

    typedef struct {
        timer_cmd_t cmd;
        bit         typed;
        timer_rsp_t want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ptb_cmd_if cmd_ch();
    ptb_rsp_if rsp_ch();

    periodic_timer_bank_with_slots #(
        .NUM_SLOTS (SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // shadow copy of the slot bank
    bit                  bank_active [SLOTS];
    bit                  bank_named  [SLOTS];
    logic [PERIOD_W-1:0] bank_count  [SLOTS];
    logic [PERIOD_W-1:0] bank_period [SLOTS];

    timer_rsp_t  rsp_pending[$];
    script_row_t script[$];
    bit          cur_typed;
    timer_rsp_t  cur_want;
    bit          idle_on;
    int          mismatches;
    int          cycles = 0;

    function automatic timer_rsp_t advance_bank(timer_cmd_t c);
        timer_rsp_t r;
        bit         done;
        r.slot = NO_SLOT;
        r.mask = '0;
        r.echo = '0;
        done   = 1'b0;
        case (c.op)
            OP_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (bank_active[i])
                    begin
                        bank_count[i] = bank_count[i] + 32'd1;
                        if (bank_count[i] >= bank_period[i])
                        begin
                            bank_count[i] = '0;
                            r.mask[i] = 1'b1;
                        end
                    end
                end
                r.echo = c.param;
            end
            OP_REGISTER:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && !bank_active[i])
                    begin
                        bank_count[i]  = '0;
                        bank_period[i] = c.period;
                        bank_named[i]  = 1'b1;
                        bank_active[i] = 1'b1;
                        r.slot = SLOT_W'(i);
                        done = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                // unnamed slots answer to id 0
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && (bank_named[i] ? i : 0) == int'(c.id))
                    begin
                        bank_active[i] = 1'b0;
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    bank_active[i] = 1'b0;
                    bank_named[i]  = 1'b1;
                    bank_count[i]  = '0;
                    bank_period[i] = '0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
        if (mismatches < PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want_v);
        mismatches++;
    endtask

    task automatic add_row(input op_t op, input logic [PERIOD_W-1:0] per,
                           input logic signed [ID_W-1:0] id, input logic [PARAM_W-1:0] prm,
                           input bit typed, input logic [SLOT_W-1:0] slot,
                           input logic [MASK_W-1:0] mask, input logic [PARAM_W-1:0] echo);
        script_row_t row;
        row.cmd.op     = op;
        row.cmd.period = per;
        row.cmd.id     = id;
        row.cmd.param  = prm;
        row.typed      = typed;
        row.want.slot  = slot;
        row.want.mask  = mask;
        row.want.echo  = echo;
        script.push_back(row);
    endtask

    // starts and ends at a falling edge
    task automatic issue_cmd(input timer_cmd_t c, input bit typed, input timer_rsp_t want);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_typed = typed;
        cur_want  = want;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.operation  <= c.op;
        cmd_ch.period     <= c.period;
        cmd_ch.remove_id  <= c.id;
        cmd_ch.tick_param <= c.param;
        do @(posedge clk); while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_bank_quiet();
        cmd_ch.valid <= 1'b0;
        do @(negedge clk); while (rsp_pending.size() != 0);
    endtask

    function automatic timer_cmd_t random_cmd();
        timer_cmd_t c;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c.op = OP_TICK;
        else if (pick < 72)
            c.op = OP_REGISTER;
        else if (pick < 96)
            c.op = OP_REMOVE;
        else
            c.op = OP_REMOVE_ALL;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            c.period = $urandom_range(0, 6);
        else if (pick < 88)
            c.period = $urandom_range(7, 40);
        else if (pick < 95)
            c.period = $urandom;
        else
            c.period = '1;
        if ($urandom_range(0, 3) != 0)
            c.id = ID_W'($signed($urandom_range(0, 4)) - 1);
        else
            c.id = ID_W'($urandom);
        c.param = $urandom;
        return c;
    endfunction

    always @(negedge clk)
    begin : sink_side
        int hold;
        if (!rst_n)
        begin
            hold = 0;
            rsp_ch.ready <= 1'b1;
        end
        else if (hold != 0)
        begin
            hold--;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            hold = $urandom_range(0, 9);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : watch
        timer_rsp_t want;
        timer_rsp_t pred;
        timer_cmd_t seen;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_pending.size() == 0)
                    flag_mismatch("unexpected beat, fired_mask", 32'(rsp_ch.fired_mask), '0);
                else
                begin
                    want = rsp_pending.pop_front();
                    if (rsp_ch.assigned_slot !== want.slot)
                        flag_mismatch("assigned_slot", 32'(rsp_ch.assigned_slot),
                                      32'(want.slot));
                    if (rsp_ch.fired_mask !== want.mask)
                        flag_mismatch("fired_mask", 32'(rsp_ch.fired_mask), 32'(want.mask));
                    if (rsp_ch.param_echo !== want.echo)
                        flag_mismatch("param_echo", rsp_ch.param_echo, want.echo);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen.op     = op_t'(cmd_ch.operation);
                seen.period = cmd_ch.period;
                seen.id     = cmd_ch.remove_id;
                seen.param  = cmd_ch.tick_param;
                pred = advance_bank(seen);
                rsp_pending.push_back(cur_typed ? cur_want : pred);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[periodic_timer_bank_with_slots] ERROR");
            $finish;
        end
    end

    initial
    begin
        timer_rsp_t none;
        int         drain;
        none.slot = '0;
        none.mask = '0;
        none.echo = '0;
        mismatches = 0;
        cur_typed  = 1'b0;
        cur_want   = none;
        idle_on    = 1'b1;
        rst_n      = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.operation  = OP_TICK;
        cmd_ch.period     = '0;
        cmd_ch.remove_id  = '0;
        cmd_ch.tick_param = '0;
        rsp_ch.ready      = 1'b1;

        // state after reset, slot naming, fill, overflow and removal corners
        add_row(OP_TICK,       '0,           8'sd0,    32'h0000_0000, 1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_TICK,       '0,           8'sd0,    32'hFFFF_FFFF, 1, NO_SLOT, 16'h0, 32'hFFFF_FFFF);
        add_row(OP_REMOVE,     '0,           8'sd0,    '0,            1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_REMOVE,     '0,           8'sd1,    '0,            1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_REGISTER,   32'd0,        8'sd0,    '0,            1, 5'd0,    16'h0, 32'h0);
        add_row(OP_TICK,       '0,           8'sd0,    32'h1234_5678, 1, NO_SLOT, 16'h1, 32'h1234_5678);
        add_row(OP_REGISTER,   32'hFFFF_FFFF, 8'sd0,   '0,            1, 5'd1,    16'h0, 32'h0);
        add_row(OP_REGISTER,   32'd2,        8'sd0,    '0,            1, 5'd2,    16'h0, 32'h0);
        add_row(OP_REGISTER,   32'd5,        8'sd0,    '0,            1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_TICK,       '0,           8'sd0,    32'hA5A5_A5A5, 1, NO_SLOT, 16'h1, 32'hA5A5_A5A5);
        add_row(OP_TICK,       '0,           8'sd0,    32'h5A5A_5A5A, 1, NO_SLOT, 16'h5, 32'h5A5A_5A5A);
        add_row(OP_REMOVE,     '0,           -8'sd128, '0,            1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_REMOVE,     '0,           8'sd127,  '0,            1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_REMOVE,     '0,           8'sd3,    '0,            1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_REMOVE,     '0,           8'sd2,    '0,            1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_TICK,       '0,           8'sd0,    32'h0000_0001, 1, NO_SLOT, 16'h1, 32'h1);
        add_row(OP_REGISTER,   32'd1,        8'sd0,    '0,            1, 5'd2,    16'h0, 32'h0);
        add_row(OP_REMOVE,     '0,           8'sd1,    '0,            1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_REMOVE,     '0,           8'sd1,    '0,            1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_TICK,       '0,           8'sd0,    32'h0000_0002, 1, NO_SLOT, 16'h5, 32'h2);
        add_row(OP_REMOVE,     '0,           8'sd0,    '0,            1, NO_SLOT, 16'h0, 32'h0);
        add_row(OP_TICK,       '0,           8'sd0,    32'h0000_0003, 0, '0,      '0,    '0);
        add_row(OP_REMOVE_ALL, 32'hFFFF_FFFF, -8'sd1,  32'hFFFF_FFFF, 0, '0,      '0,    '0);
        add_row(OP_TICK,       '0,           8'sd0,    32'h8000_0001, 0, '0,      '0,    '0);
        add_row(OP_REGISTER,   32'd3,        8'sd0,    '0,            0, '0,      '0,    '0);

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[k])
            issue_cmd(script[k].cmd, script[k].typed, script[k].want);
        wait_bank_quiet();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            idle_on = !(n >= 400 && n < 500) && (n < RAND_ITEMS - QUIET_TAIL);
            if (n == 700)
                wait_bank_quiet();
            issue_cmd(random_cmd(), 1'b0, none);
        end
        cmd_ch.valid <= 1'b0;

        drain = 0;
        while (rsp_pending.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (4) @(negedge clk);
        if (rsp_pending.size() != 0)
            flag_mismatch("beats still expected", 32'(rsp_pending.size()), '0);

        if (mismatches == 0)
            $display("[periodic_timer_bank_with_slots] OK");
        else
            $display("[periodic_timer_bank_with_slots] ERROR");
        $finish;
    end

endmodule
